[hw/rtl/sspq_pkg.sv]
// sspq_pkg: shared types, constants and sequencer states for the stable sorted
// priority queue. The top level uses it; the entry ram does not.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sspq_pkg;

   localparam int DEPTH     = 16;
   localparam int TAG_WIDTH = 16;

   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int PRIO_W   = 16;
   localparam int TAG_IN_W = 16;
   localparam int OCC_W    = 5;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [PRIO_W-1:0] priority_req;
      logic [TAG_IN_W-1:0]      payload_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [PRIO_W-1:0] front_priority;
      logic [TAG_IN_W-1:0]      front_tag;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_WIDTH-1:0]     tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PUSH_RD,
      S_PUSH_CMP,
      S_PUSH_PUT,
      S_POP_RD,
      S_POP_WR,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/sspq_ram.sv]
// sspq_ram: generic simple dual port ram, one write and one registered read
// per cycle. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sspq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hw/rtl/stable_sorted_priority_queue_top.sv]
// stable_sorted_priority_queue_top: bounded priority queue kept in ascending
// priority order, one ram of entries walked by a small sequencer.
// Depends on sspq_pkg and sspq_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   A transaction is accepted at a rising edge with start high and busy low;
//   req_data carries operation (push, pop, peek), priority and tag.
//   busy stays high until the result is produced. Exactly one result follows
//   each transaction: rsp_valid is high for one cycle with rsp_data holding
//   status, front entry after the operation (zero when empty) and occupancy.
//   The receiver cannot stall; the result must be taken in that cycle.
//   A push lands after every entry of equal or smaller priority, so equal
//   priorities leave in arrival order. A push on a full queue is dropped
//   with overflow status; pop or peek on an empty queue gives underflow.
// Timing:
//   The entry ram has one write and one registered read port, so moving an
//   entry takes a read state and then a write state. From accept, the
//   sequencer passes S_EXEC, then any read and write states that move
//   entries, then S_DONE; the strobe is registered from S_DONE. A new
//   transaction may be accepted in the cycle the strobe is high.
// Reset:
//   Synchronous reset empties the queue and clears the sequencer; the ram
//   contents are left as they are, only slots below the count are read.

module stable_sorted_priority_queue_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire sspq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output sspq_pkg::rsp_type     rsp_data
);

   sspq_pkg::state_type state_ff, state_in;
   sspq_pkg::req_type   req_ff, req_in;
   sspq_pkg::entry_type front_ff, front_in;
   sspq_pkg::rsp_type   rsp_ff, rsp_in;
   logic [sspq_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic [sspq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [1:0]                  status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                         ram_we;
   logic [sspq_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
   sspq_pkg::entry_type          ram_wdata, ram_rdata;
   logic [sspq_pkg::ENTRY_W-1:0] ram_rbits;

   sspq_pkg::entry_type new_entry;
   logic                accept, is_full, is_empty, shift_on, pop_last;

   assign accept    = start && !busy;
   assign busy      = (state_ff != sspq_pkg::S_IDLE);
   assign is_full   = (count_ff == sspq_pkg::CNT_W'(sspq_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);
   assign ram_rdata = sspq_pkg::entry_type'(ram_rbits);
   assign new_entry = '{prio: req_ff.priority_req,
                        tag:  sspq_pkg::TAG_WIDTH'(req_ff.payload_tag)};
   // stored entry ranks after the new one, so it moves up a slot
   assign shift_on  = ($signed(ram_rdata.prio) > $signed(req_ff.priority_req));
   assign pop_last  = ((sspq_pkg::CNT_W'(idx_ff) + sspq_pkg::CNT_W'(1)) == count_ff);

   sspq_ram #(
      .WIDTH(sspq_pkg::ENTRY_W),
      .DEPTH(sspq_pkg::DEPTH)
   ) u_entries (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rbits)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sspq_pkg::S_IDLE: begin
            if (accept) state_in = sspq_pkg::S_EXEC;
         end
         sspq_pkg::S_EXEC: begin
            state_in = sspq_pkg::S_DONE;
            if (req_ff.operation == sspq_pkg::OP_PUSH) begin
               if (!is_full && !is_empty) state_in = sspq_pkg::S_PUSH_RD;
            end else if (req_ff.operation == sspq_pkg::OP_POP) begin
               if (count_ff > sspq_pkg::CNT_W'(1)) state_in = sspq_pkg::S_POP_RD;
            end
         end
         sspq_pkg::S_PUSH_RD: state_in = sspq_pkg::S_PUSH_CMP;
         sspq_pkg::S_PUSH_CMP: begin
            if (!shift_on) begin
               state_in = sspq_pkg::S_DONE;
            end else if (idx_ff == sspq_pkg::ADDR_W'(1)) begin
               state_in = sspq_pkg::S_PUSH_PUT;
            end else begin
               state_in = sspq_pkg::S_PUSH_RD;
            end
         end
         sspq_pkg::S_PUSH_PUT: state_in = sspq_pkg::S_DONE;
         sspq_pkg::S_POP_RD:   state_in = sspq_pkg::S_POP_WR;
         sspq_pkg::S_POP_WR: begin
            state_in = pop_last ? sspq_pkg::S_DONE : sspq_pkg::S_POP_RD;
         end
         sspq_pkg::S_DONE: state_in = sspq_pkg::S_IDLE;
         default:          state_in = sspq_pkg::S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      req_in       = req_ff;
      front_in     = front_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = new_entry;
      ram_raddr    = idx_ff;
      case (state_ff)
         sspq_pkg::S_IDLE: begin
            if (accept) req_in = req_data;
         end
         sspq_pkg::S_EXEC: begin
            status_in = sspq_pkg::STATUS_OK;
            if (req_ff.operation == sspq_pkg::OP_PUSH) begin
               if (is_full) begin
                  status_in = sspq_pkg::STATUS_OVERFLOW;
               end else if (is_empty) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  front_in  = new_entry;
                  count_in  = count_ff + sspq_pkg::CNT_W'(1);
               end else begin
                  idx_in = sspq_pkg::ADDR_W'(count_ff);
               end
            end else if (req_ff.operation == sspq_pkg::OP_POP) begin
               if (is_empty) begin
                  status_in = sspq_pkg::STATUS_UNDERFLOW;
               end else if (count_ff == sspq_pkg::CNT_W'(1)) begin
                  count_in = '0;
               end else begin
                  idx_in = sspq_pkg::ADDR_W'(1);
               end
            end else begin
               // peek, and the unused code behaves as peek
               if (is_empty) status_in = sspq_pkg::STATUS_UNDERFLOW;
            end
         end
         sspq_pkg::S_PUSH_RD: begin
            ram_raddr = idx_ff - sspq_pkg::ADDR_W'(1);
         end
         sspq_pkg::S_PUSH_CMP: begin
            ram_we = 1'b1;
            if (shift_on) begin
               ram_wdata = ram_rdata;
               idx_in    = idx_ff - sspq_pkg::ADDR_W'(1);
            end else begin
               count_in = count_ff + sspq_pkg::CNT_W'(1);
            end
         end
         sspq_pkg::S_PUSH_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            front_in  = new_entry;
            count_in  = count_ff + sspq_pkg::CNT_W'(1);
         end
         sspq_pkg::S_POP_RD: begin
            ram_raddr = idx_ff;
         end
         sspq_pkg::S_POP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff - sspq_pkg::ADDR_W'(1);
            ram_wdata = ram_rdata;
            if (idx_ff == sspq_pkg::ADDR_W'(1)) front_in = ram_rdata;
            if (pop_last) begin
               count_in = count_ff - sspq_pkg::CNT_W'(1);
            end else begin
               idx_in = idx_ff + sspq_pkg::ADDR_W'(1);
            end
         end
         sspq_pkg::S_DONE: begin
            rsp_valid_in             = 1'b1;
            rsp_in.status            = status_ff;
            rsp_in.front_priority    = is_empty ? '0 : front_ff.prio;
            rsp_in.front_tag         = is_empty ? '0 : sspq_pkg::TAG_IN_W'(front_ff.tag);
            rsp_in.occupancy         = sspq_pkg::OCC_W'(count_ff);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sspq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      front_ff  <= front_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sspq_pkg::CNT_W'(sspq_pkg::DEPTH))
      else $error("entry count above depth");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == sspq_pkg::STATUS_OVERFLOW)
      |-> (rsp_data.occupancy == sspq_pkg::OCC_W'(sspq_pkg::DEPTH)))
      else $error("overflow reported on a queue that is not full");

endmodule

`default_nettype wire
